// File: sv/stb_pkg.sv
`default_nettype none
package stb_pkg;

  // Default size of the bank and the cap on expiry words per tick
  localparam int NumTimersDefault = 8;
  localparam int MaxResults       = 8;

  // Bit positions inside a slot's flag nibble
  localparam int FlagUsed    = 0;
  localparam int FlagStarted = 1;
  localparam int FlagHigh    = 2;
  localparam int FlagOneShot = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_NONE   = 2'd3
  } stb_op_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } stb_kind_t;

  // Command token that walks the cell chain
  typedef struct packed {
    stb_op_t     op;
    logic        cls;
    logic [7:0]  idx;
    logic [15:0] per;
    logic [1:0]  cflags;
    logic [3:0]  mask;
    logic        setf;
    logic        ok;
  } stb_tok_t;

endpackage
`default_nettype wire

// File: sv/stb_cell.sv
`default_nettype none
module stb_cell #(
  parameter int INDEX = 0
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              en,
  input  wire              tok_in_valid,
  input  stb_pkg::stb_tok_t tok_in,
  output logic             tok_out_valid,
  output stb_pkg::stb_tok_t tok_out,
  output logic             hit
);
  import stb_pkg::*;

  logic [15:0] count;
  logic [15:0] period;
  logic [3:0]  flags;

  logic [15:0] count_inc;
  logic        sel;
  logic        tick_match;
  logic        expire;
  logic        create_ok;
  logic        change_ok;
  stb_tok_t    tok_out_next;

  always_comb begin
    count_inc  = count + 16'd1;
    sel        = tok_in_valid && (tok_in.idx == 8'(INDEX));
    tick_match = tok_in_valid && (tok_in.op == OP_TICK) && flags[FlagUsed] &&
                 flags[FlagStarted] && (flags[FlagHigh] == tok_in.cls);
    expire     = tick_match && (count_inc == period);
    create_ok  = sel && (tok_in.op == OP_CREATE) && !flags[FlagUsed];
    change_ok  = sel && (tok_in.op == OP_CHANGE) && flags[FlagUsed];
    tok_out_next    = tok_in;
    tok_out_next.ok = tok_in.ok | create_ok | change_ok;
  end

  // Slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flags <= '0;
    end else if (en) begin
      if (tick_match) begin
        if (expire) begin
          count <= '0;
          if (flags[FlagOneShot]) flags[FlagStarted] <= 1'b0;
        end else begin
          count <= count_inc;
        end
      end
      if (create_ok) begin
        count                <= '0;
        flags[FlagUsed]      <= 1'b1;
        flags[FlagStarted]   <= 1'b0;
        flags[FlagHigh]      <= tok_in.cflags[1];
        flags[FlagOneShot]   <= tok_in.cflags[0];
      end
      if (change_ok) begin
        flags <= tok_in.setf ? (flags | tok_in.mask) : (flags & ~tok_in.mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && create_ok) period <= tok_in.per;
  end

  // Hand the token to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else if (en) begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out <= tok_out_next;
      hit     <= expire;
    end
  end

endmodule
`default_nettype wire

// File: sv/software_timer_bank_unit.sv
// A word walks one cell per cycle while the chain advances, then the tail register; the final
// word of an input (status, or the last expiry of a tick) is loaded from the tail. Each expiry word
// is held until the next expiry or the end of the walk shows whether it is the final one.
// No new input word is taken until the walk through the chain is done.
// Output backpressure freezes the whole chain.
// Reset (rst, synchronous, active high) frees every slot and clears all counts.
`default_nettype none
module software_timer_bank_unit #(
  parameter int NUM_TIMERS = stb_pkg::NumTimersDefault
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  // s_tdata from bit 0: tick_class, timer_index[7:0], period[15:0], create_flags[1:0],
  // flag_mask[3:0], set_flags
  input  wire [31:0] s_tdata,
  // s_tuser from bit 0: op[1:0]
  input  wire [1:0]  s_tuser,
  output logic       m_tvalid,
  input  wire        m_tready,
  // m_tdata from bit 0: expired_index[2:0], status, then zero fill
  output logic [7:0] m_tdata,
  // m_tuser from bit 0: result_kind
  output logic [0:0] m_tuser,
  output logic       m_tlast
);
  import stb_pkg::*;

  localparam int CntW = $clog2(MaxResults + 1);

  // Chain taps, one per cell
  logic [NUM_TIMERS-1:0] vld;
  logic [NUM_TIMERS-1:0] hit;
  stb_tok_t              tok [NUM_TIMERS];
  stb_tok_t              tok_head;

  logic     advance;
  logic     accept;
  logic     busy;
  logic     tail_valid;
  stb_tok_t tail_tok;

  // Expiry held back until we know whether it is the final one
  logic            pend_valid;
  logic [2:0]      pend_index;
  logic [CntW-1:0] n_ev;

  logic       ev;
  logic [2:0] ev_index;
  logic       ev_take;

  logic       load;
  stb_kind_t  ld_kind;
  logic [2:0] ld_index;
  logic       ld_status;
  logic       ld_last;

  stb_kind_t  out_kind;
  logic [2:0] out_index;
  logic       out_status;
  logic       out_last;

  // The whole chain moves only when the output register can take a word
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !busy && advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    tok_head.op     = stb_op_t'(s_tuser);
    tok_head.cls    = s_tdata[0];
    tok_head.idx    = s_tdata[8:1];
    tok_head.per    = s_tdata[24:9];
    tok_head.cflags = s_tdata[26:25];
    tok_head.mask   = s_tdata[30:27];
    tok_head.setf   = s_tdata[31];
    tok_head.ok     = 1'b0;
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      stb_cell #(.INDEX(i)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .en           (advance),
        .tok_in_valid (accept),
        .tok_in       (tok_head),
        .tok_out_valid(vld[i]),
        .tok_out      (tok[i]),
        .hit          (hit[i])
      );
    end else begin : g_body
      stb_cell #(.INDEX(i)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .en           (advance),
        .tok_in_valid (vld[i-1]),
        .tok_in       (tok[i-1]),
        .tok_out_valid(vld[i]),
        .tok_out      (tok[i]),
        .hit          (hit[i])
      );
    end
  end

  // Only one token is in flight, so at most one tap is live
  always_comb begin
    ev       = |(vld & hit);
    ev_index = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (vld[i] && hit[i]) ev_index = 3'(i);
    end
    ev_take = ev && (n_ev < CntW'(MaxResults));
  end

  // Output word selection
  always_comb begin
    load      = 1'b0;
    ld_kind   = KIND_EXPIRY;
    ld_index  = pend_index;
    ld_status = 1'b0;
    ld_last   = 1'b0;
    if (advance) begin
      if (ev_take && pend_valid) begin
        load = 1'b1;
      end
      if (tail_valid) begin
        case (tail_tok.op)
          OP_TICK: begin
            load    = pend_valid;
            ld_last = 1'b1;
          end
          OP_CREATE, OP_CHANGE: begin
            load      = 1'b1;
            ld_kind   = KIND_STATUS;
            ld_index  = '0;
            ld_status = !tail_tok.ok;
            ld_last   = 1'b1;
          end
          default: begin
            load = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tail_valid <= 1'b0;
      pend_valid <= 1'b0;
      n_ev       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        n_ev <= '0;
      end else if (advance && tail_valid) begin
        busy <= 1'b0;
      end
      if (advance) begin
        tail_valid <= vld[NUM_TIMERS-1];
        if (ev_take) begin
          pend_valid <= 1'b1;
          n_ev       <= n_ev + CntW'(1);
        end else if (tail_valid) begin
          pend_valid <= 1'b0;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tail_tok <= tok[NUM_TIMERS-1];
      if (ev_take) pend_index <= ev_index;
    end
    if (load) begin
      out_kind   <= ld_kind;
      out_index  <= ld_index;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  assign m_tdata = {4'b0000, out_status, out_index};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // At most one token anywhere in the chain or the tail
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({vld, tail_valid}))
    else $error("more than one token in the cell chain");

  // Input is only taken when the chain is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (vld == '0) && !tail_valid && !pend_valid)
    else $error("input ready while a walk is in progress");

  // A held expiry belongs to a walk in progress
  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("pending expiry outside a walk");

  // Status words are always the final word of their input
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
    else $error("status word without last");

  // Never more expiry words than the cap per tick
  a_ev_cap: assert property (@(posedge clk) disable iff (rst)
    n_ev <= CntW'(MaxResults))
    else $error("expiry count over cap");
`endif

endmodule
`default_nettype wire
